/* hw/rtl/sht_pkg.sv */
package sht_pkg;

    // Fixed field widths of the transaction payloads
    localparam int FUNC_W   = 2;
    localparam int SLOT_W   = 6;
    localparam int DATA_W   = 64;
    localparam int STATUS_W = 3;
    localparam int COUNT_W  = 7;

    // APB port
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    // Register indexes (paddr[PADDR_W-1])
    localparam logic REG_ACTIVE_SLOTS   = 1'b0;
    localparam logic REG_COMPARE_ENABLE = 1'b1;

    localparam logic [COUNT_W-1:0] ACTIVE_SLOTS_RST = 7'd64;

    // Operation codes
    localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_FIND   = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd2;

    // Status codes
    localparam logic [STATUS_W-1:0] STAT_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_FULL      = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_SLOT_FREE = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_MISMATCH  = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_BAD_SLOT  = 3'd4;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [SLOT_W-1:0] slot;
        logic [DATA_W-1:0] value_in;
        logic [DATA_W-1:0] key;
        logic              key_given;
    } t_in_item;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   slot_out;
        logic [DATA_W-1:0]   value_out;
        logic [COUNT_W-1:0]  entries_used;
    } t_out_item;

endpackage

/* hw/rtl/sht_ram.sv */
module sht_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* hw/rtl/slot_handle_table.sv */
// Round-robin slot table: SLOTS slots of VALUE_BITS-bit values, each with an occupied flag.
// Insert scans from a rotating start pointer for the first free slot (wrapping at the active
// slot count), find reads a slot back, remove frees it; every result carries the entry count.
// One transaction is in work at a time. Find and remove step from acceptance to the next
// acceptance through addressing the value RAM, its registered read, the check and the load
// of the output register; a bad slot index or unused code goes straight to the load. Insert
// scans k slots (1 up to the active count), testing one occupied flag per cycle with a single
// increment/compare unit; every load waits for room in the output register.
// Values sit in a single-port-write, registered-read RAM; no clearing pass is needed after
// reset, as a slot whose occupied flag is clear reads as zero.
module slot_handle_table #(
    parameter int SLOTS      = 64,
    parameter int VALUE_BITS = 64
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // request channel
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  sht_pkg::t_in_item            i_in,
    // result channel
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output sht_pkg::t_out_item           o_out,
    // APB configuration port
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [sht_pkg::PADDR_W-1:0]  paddr,
    input  logic [sht_pkg::PDATA_W-1:0]  pwdata,
    output logic [sht_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready
);

    import sht_pkg::*;

    // IW indexes a slot, EW holds a count up to SLOTS
    localparam int IW = $clog2(SLOTS);
    localparam int EW = IW + 1;
    localparam int MW = (EW > COUNT_W) ? EW : COUNT_W;
    localparam logic [MW-1:0] SLOTS_M = MW'(SLOTS);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_SCAN  = 5'b00010,
        ST_READ  = 5'b00100,
        ST_CHECK = 5'b01000,
        ST_FIN   = 5'b10000
    } t_state;

    // configuration
    logic [COUNT_W-1:0] r_active;
    logic               r_cmp_en;

    // sequencer and table state
    t_state             r_state,  n_state;
    t_in_item           r_item,   n_item;
    logic [SLOTS-1:0]   r_occ,    n_occ;
    logic [EW-1:0]      r_start,  n_start;
    logic [EW-1:0]      r_used,   n_used;
    logic [IW-1:0]      r_idx,    n_idx;
    logic [EW-1:0]      r_cnt,    n_cnt;
    t_out_item          r_res,    n_res;

    // output register
    t_out_item          r_out;
    logic               r_out_valid;

    // value RAM port signals
    logic                  ram_we;
    logic [IW-1:0]         ram_waddr;
    logic [VALUE_BITS-1:0] ram_wdata;
    logic [IW-1:0]         rd_slot;
    logic [VALUE_BITS-1:0] ram_rdata;

    logic [MW-1:0]         act_m;
    logic [MW-1:0]         act_eff_m;
    logic [EW-1:0]         act_eff;
    logic [EW-1:0]         start_eff;
    logic                  in_acc;
    logic                  out_free;
    logic                  bad_req;
    logic                  cfg_wr;

    // scan unit
    logic [EW-1:0]         idx_nx;
    logic                  idx_wrap;
    logic                  cnt_last;
    logic                  idx_free;

    // check stage
    logic [VALUE_BITS-1:0] stored;
    logic                  mismatch;

    // ---------------------------------------------------------------------------------------
    // Configuration: active count is clamped to 1..SLOTS for use
    // ---------------------------------------------------------------------------------------
    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= ACTIVE_SLOTS_RST;
            r_cmp_en <= 1'b1;
        end else if (cfg_wr) begin
            case (paddr[PADDR_W-1])
                REG_ACTIVE_SLOTS:   r_active <= pwdata[COUNT_W-1:0];
                REG_COMPARE_ENABLE: r_cmp_en <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[PADDR_W-1])
            REG_ACTIVE_SLOTS:   prdata = PDATA_W'(r_active);
            REG_COMPARE_ENABLE: prdata = PDATA_W'(r_cmp_en);
            default:            prdata = '0;
        endcase
    end

    assign act_m = MW'(r_active);

    always_comb begin
        if (act_m == '0) begin
            act_eff_m = MW'(1);
        end else if (act_m > SLOTS_M) begin
            act_eff_m = SLOTS_M;
        end else begin
            act_eff_m = act_m;
        end
    end

    assign act_eff = act_eff_m[EW-1:0];

    // ---------------------------------------------------------------------------------------
    // Handshakes
    // ---------------------------------------------------------------------------------------
    assign o_in_ready = (r_state == ST_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;
    // the output register can take a new result when empty or being drained this cycle
    assign out_free   = !r_out_valid || i_out_ready;

    // a start pointer at or past the active count (wrapped, or count lowered since) restarts at slot zero
    assign start_eff = (r_start >= act_eff) ? '0 : r_start;

    // find/remove on an unused code or a slot outside the active range
    assign bad_req = (i_in.func != FUNC_FIND && i_in.func != FUNC_REMOVE)
                     || (MW'(i_in.slot) >= act_eff_m);

    // ---------------------------------------------------------------------------------------
    // Scan unit: one occupied flag per cycle, index wraps at the active count
    // ---------------------------------------------------------------------------------------
    assign idx_nx   = EW'(r_idx) + 1'b1;
    assign idx_wrap = (idx_nx == act_eff);
    assign cnt_last = ((r_cnt + 1'b1) == act_eff);
    assign idx_free = !r_occ[r_idx];

    // ---------------------------------------------------------------------------------------
    // Check stage: a free slot always reads as zero, so no RAM clear is needed
    // ---------------------------------------------------------------------------------------
    assign rd_slot  = IW'(r_item.slot);
    assign stored   = r_occ[rd_slot] ? ram_rdata : '0;
    assign mismatch = (stored != r_item.key[VALUE_BITS-1:0]);

    // ---------------------------------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------------------------------
    always_comb begin
        n_state   = r_state;
        n_item    = r_item;
        n_occ     = r_occ;
        n_start   = r_start;
        n_used    = r_used;
        n_idx     = r_idx;
        n_cnt     = r_cnt;
        n_res     = r_res;
        ram_we    = 1'b0;
        ram_waddr = r_idx;
        ram_wdata = r_item.value_in[VALUE_BITS-1:0];

        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_item             = i_in;
                    n_res.status       = STAT_OK;
                    n_res.slot_out     = i_in.slot;
                    n_res.value_out    = '0;
                    n_res.entries_used = COUNT_W'(r_used);
                    if (i_in.func == FUNC_INSERT) begin
                        // pointer advances whether or not a slot turns up
                        n_idx   = start_eff[IW-1:0];
                        n_start = start_eff + 1'b1;
                        n_cnt   = '0;
                        n_state = ST_SCAN;
                    end else if (bad_req) begin
                        n_res.status = STAT_BAD_SLOT;
                        n_state      = ST_FIN;
                    end else begin
                        n_state = ST_READ;
                    end
                end
            end

            ST_SCAN: begin
                if (idx_free) begin
                    n_occ[r_idx]       = 1'b1;
                    ram_we             = 1'b1;
                    n_used             = r_used + 1'b1;
                    n_res.slot_out     = SLOT_W'(r_idx);
                    n_res.entries_used = COUNT_W'(n_used);
                    n_state            = ST_FIN;
                end else if (cnt_last) begin
                    // whole active range seen occupied
                    n_res.status   = STAT_FULL;
                    n_res.slot_out = '0;
                    n_state        = ST_FIN;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                    n_idx = idx_wrap ? '0 : idx_nx[IW-1:0];
                end
            end

            // RAM address presented this cycle, data registered for the check
            ST_READ: begin
                n_state = ST_CHECK;
            end

            ST_CHECK: begin
                if (r_item.func == FUNC_FIND) begin
                    if (r_cmp_en && mismatch) begin
                        n_res.status = STAT_MISMATCH;
                    end else begin
                        n_res.value_out = DATA_W'(stored);
                    end
                end else if (!r_occ[rd_slot]) begin
                    n_res.status = STAT_SLOT_FREE;
                end else if (r_cmp_en && r_item.key_given && mismatch) begin
                    n_res.status = STAT_MISMATCH;
                end else begin
                    n_res.value_out    = DATA_W'(stored);
                    n_occ[rd_slot]     = 1'b0;
                    n_used             = r_used - 1'b1;
                    n_res.entries_used = COUNT_W'(n_used);
                end
                n_state = ST_FIN;
            end

            // wait for room in the output register
            ST_FIN: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_occ   <= '0;
            r_start <= '0;
            r_used  <= '0;
        end else begin
            r_state <= n_state;
            r_occ   <= n_occ;
            r_start <= n_start;
            r_used  <= n_used;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item <= n_item;
        r_idx  <= n_idx;
        r_cnt  <= n_cnt;
        r_res  <= n_res;
    end

    // ---------------------------------------------------------------------------------------
    // Output register
    // ---------------------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == ST_FIN && out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_FIN && out_free) begin
            r_out <= r_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // ---------------------------------------------------------------------------------------
    // Value store
    // ---------------------------------------------------------------------------------------
    sht_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (SLOTS)
    ) u_values (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (rd_slot),
        .o_rdata (ram_rdata)
    );

`ifndef NO_ASSERTIONS
    // entry count tracks the occupied flags
    a_count_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used == EW'($countones(r_occ)))
        else $error("entry count out of step with occupied flags");

    // scan never examines more slots than the active range
    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> (r_cnt < act_eff) && (EW'(r_idx) < act_eff))
        else $error("scan ran past the active range");

    // a result appears only from the finish step
    a_out_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == ST_FIN))
        else $error("result loaded outside finish step");

    // reported count is the count after the operation
    a_count_reported: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FIN && out_free) |=> (o_out.entries_used == COUNT_W'(r_used)))
        else $error("reported entry count differs from table");
`endif

endmodule
